// File: design/m4inv_pkg.sv
// ---------------------------------------------------------------------------
// m4inv_pkg - shared types and tables for the 4x4 matrix inverter
// Sequencer states, phases and the cofactor index tables.
// ---------------------------------------------------------------------------
package m4inv_pkg;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_RD0  = 13'b0000000000010,
    ST_RD1  = 13'b0000000000100,
    ST_RD2  = 13'b0000000001000,
    ST_MUL  = 13'b0000000010000,
    ST_ACC  = 13'b0000000100000,
    ST_NEXT = 13'b0000001000000,
    ST_DABS = 13'b0000010000000,
    ST_NABS = 13'b0000100000000,
    ST_DIV  = 13'b0001000000000,
    ST_FIN  = 13'b0010000000000,
    ST_SRD  = 13'b0100000000000,
    ST_SOUT = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_SUB = 3'b001,
    PH_DET = 3'b010,
    PH_ADJ = 3'b100
  } phase_t;

  localparam int unsigned LAST_POS  = 15;
  localparam int unsigned SUB_TERMS = 24;
  localparam int unsigned DET_TERMS = 6;
  localparam int unsigned ADJ_TERMS = 3;

  // sub-determinant k = e[a]*e[b] - e[c]*e[d]
  localparam logic [3:0] SUB_TAB [12][4] = '{
    '{4'd0, 4'd5, 4'd1, 4'd4}, '{4'd0, 4'd6, 4'd2, 4'd4},
    '{4'd0, 4'd7, 4'd3, 4'd4}, '{4'd1, 4'd6, 4'd2, 4'd5},
    '{4'd1, 4'd7, 4'd3, 4'd5}, '{4'd2, 4'd7, 4'd3, 4'd6},
    '{4'd8, 4'd13, 4'd9, 4'd12}, '{4'd8, 4'd14, 4'd10, 4'd12},
    '{4'd8, 4'd15, 4'd11, 4'd12}, '{4'd9, 4'd14, 4'd10, 4'd13},
    '{4'd9, 4'd15, 4'd11, 4'd13}, '{4'd10, 4'd15, 4'd11, 4'd14}
  };

  // determinant = sum of +/- s[a]*s[b]
  localparam logic [3:0] DET_A   [6] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd4};
  localparam logic [3:0] DET_B   [6] = '{4'd11, 4'd10, 4'd9, 4'd8, 4'd6, 4'd7};
  localparam logic       DET_NEG [6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  // adjugate k = +e*s - e*s + e*s, negated where ADJ_NEG[k] is set; pairs (e index, s index)
  localparam logic [3:0] ADJ_TAB [16][6] = '{
    '{4'd5, 4'd11, 4'd6, 4'd10, 4'd7, 4'd9},  '{4'd1, 4'd11, 4'd2, 4'd10, 4'd3, 4'd9},
    '{4'd13, 4'd5, 4'd14, 4'd4, 4'd15, 4'd3}, '{4'd9, 4'd5, 4'd10, 4'd4, 4'd11, 4'd3},
    '{4'd4, 4'd11, 4'd6, 4'd8, 4'd7, 4'd7},   '{4'd0, 4'd11, 4'd2, 4'd8, 4'd3, 4'd7},
    '{4'd12, 4'd5, 4'd14, 4'd2, 4'd15, 4'd1}, '{4'd8, 4'd5, 4'd10, 4'd2, 4'd11, 4'd1},
    '{4'd4, 4'd10, 4'd5, 4'd8, 4'd7, 4'd6},   '{4'd0, 4'd10, 4'd1, 4'd8, 4'd3, 4'd6},
    '{4'd12, 4'd4, 4'd13, 4'd2, 4'd15, 4'd0}, '{4'd8, 4'd4, 4'd9, 4'd2, 4'd11, 4'd0},
    '{4'd4, 4'd9, 4'd5, 4'd7, 4'd6, 4'd6},    '{4'd0, 4'd9, 4'd1, 4'd7, 4'd2, 4'd6},
    '{4'd12, 4'd3, 4'd13, 4'd1, 4'd14, 4'd0}, '{4'd8, 4'd3, 4'd9, 4'd1, 4'd10, 4'd0}
  };
  localparam logic ADJ_NEG [16] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
  };

endpackage

// File: design/matrix4x4_invert.sv
// ---------------------------------------------------------------------------
// matrix4x4_invert - 4x4 fixed-point matrix inverse, cofactor method
// Loads 16 column-major elements; position 15 starts the inversion and
// 16 result items follow, in position order.
// ---------------------------------------------------------------------------
// channel | dir | handshake        | contents
// in_     | in  | tvalid / tready  | tdata: element value, element position
// out_    | out | tvalid / tready  | tdata: value, position; tuser: flags;
//         |     |                  | tlast: sixteenth result
//
// Elements load one per cycle while idle. An inversion runs on one shared
// adder: products are shift-add, MSB first, one multiplier bit per cycle,
// and the quotient is restoring division, one bit per cycle. A singular
// matrix ends after the determinant and returns the stored elements, each
// read in ST_SRD and sent in ST_SOUT. in_tready is low for the whole run; a
// stalled out_tready holds the sequencer at the result being emitted.
// Reset clears control only.
// ---------------------------------------------------------------------------
module matrix4x4_invert
  import m4inv_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [DATA_WIDTH-1:0] element_value, [DATA_WIDTH+3:DATA_WIDTH] element_position
  input  logic [((DATA_WIDTH+4+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [DATA_WIDTH-1:0] result_value, [DATA_WIDTH+3:DATA_WIDTH] result_position
  output logic [((DATA_WIDTH+4+7)/8)*8-1:0] out_tdata,
  // [0] is_singular, [1] saturated
  output logic [1:0] out_tuser,
  output logic out_tlast
);

  localparam int W   = DATA_WIDTH;
  localparam int TDW = ((DATA_WIDTH + 4 + 7) / 8) * 8;
  localparam int MW  = 2 * W + 1;           // sub-determinant width
  localparam int AW  = 4 * W + 4;           // accumulator / remainder width
  localparam int NA  = 3 * W + 3;           // adjugate magnitude width
  localparam int NB  = NA + 2 * FRAC_BITS;  // dividend width
  localparam int MCW = $clog2(MW);
  localparam int DCW = $clog2(NB);

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic [4:0]     tcnt_r, tcnt_nxt;
  logic [3:0]     k_r, k_nxt;
  logic [MCW-1:0] mcnt_r, mcnt_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [MW-1:0]  m_r, m_nxt;
  logic [AW-1:0]  b_r, b_nxt, p_r, p_nxt, t_r, t_nxt, d_r, d_nxt, rem_r, rem_nxt;
  logic           dneg_r, dneg_nxt, qneg_r, qneg_nxt, over_r, over_nxt;
  logic [NB-1:0]  n_r, n_nxt;
  logic [W-1:0]   q_r, q_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [W-1:0]   out_value_r, out_value_nxt;
  logic [3:0]     out_pos_r, out_pos_nxt;
  logic           out_sing_r, out_sing_nxt, out_sat_r, out_sat_nxt;
  logic           out_last_r, out_last_nxt;

  // memories
  logic         in_acc;
  logic [3:0]   e_raddr, s_raddr, s_waddr;
  logic [W-1:0] e_rdata;
  logic [MW-1:0] s_rdata;
  logic         s_we;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  m4inv_ram #(.WIDTH(W), .DEPTH(16)) u_e_ram (
    .clk(clk), .we(in_acc), .waddr(in_tdata[W+3:W]), .wdata(in_tdata[W-1:0]),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  m4inv_ram #(.WIDTH(MW), .DEPTH(12)) u_s_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(t_r[MW-1:0]),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // term decode
  logic [3:0]     x_addr, y_addr;
  logic           term_neg;
  logic [MCW-1:0] nb_m1;
  logic           m_bit, m_first;
  always_comb begin
    x_addr   = 4'd0;
    y_addr   = 4'd0;
    term_neg = 1'b0;
    nb_m1    = MCW'(W - 1);
    unique case (ph_r)
      PH_SUB: begin
        x_addr   = SUB_TAB[tcnt_r[4:1]][{tcnt_r[0], 1'b0}];
        y_addr   = SUB_TAB[tcnt_r[4:1]][{tcnt_r[0], 1'b1}];
        term_neg = tcnt_r[0];
      end
      PH_DET: begin
        x_addr   = DET_A[tcnt_r[2:0]];
        y_addr   = DET_B[tcnt_r[2:0]];
        term_neg = DET_NEG[tcnt_r[2:0]];
        nb_m1    = MCW'(MW - 1);
      end
      PH_ADJ: begin
        x_addr   = ADJ_TAB[k_r][{tcnt_r[1:0], 1'b0}];
        y_addr   = ADJ_TAB[k_r][{tcnt_r[1:0], 1'b1}];
        term_neg = (tcnt_r[1:0] == 2'd1) ^ ADJ_NEG[k_r];
      end
      default: ;
    endcase
  end

  assign m_bit   = m_r[mcnt_r];
  assign m_first = (mcnt_r == nb_m1);

  // the shared adder
  logic [AW-1:0] add_a, add_b, rem_sh;
  logic          add_sub;
  logic [AW:0]   sum;
  assign rem_sh = {rem_r[AW-2:0], n_r[NB-1]};

  always_comb begin
    add_a   = t_r;
    add_b   = p_r;
    add_sub = term_neg;
    unique case (state_r)
      ST_MUL: begin
        add_a   = {p_r[AW-2:0], 1'b0};
        add_b   = m_bit ? b_r : '0;
        add_sub = m_bit && m_first;
      end
      ST_DABS, ST_NABS: begin
        add_a   = '0;
        add_b   = t_r;
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = rem_sh;
        add_b   = d_r;
        add_sub = 1'b1;
      end
      default: ;
    endcase
    sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {{AW{1'b0}}, add_sub};
  end

  // quotient finish
  logic          out_free, fin_sat;
  logic [W-1:0]  fin_val;
  assign out_free = !out_valid_r || out_tready;
  always_comb begin
    fin_sat = over_r || (qneg_r ? (q_r > {1'b1, {(W-1){1'b0}}}) : q_r[W-1]);
    fin_val = qneg_r ? (~q_r + {{(W-1){1'b0}}, 1'b1}) : q_r;
    if (fin_sat) begin
      fin_val = {qneg_r, {(W-1){~qneg_r}}};
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;  ph_nxt = ph_r;  tcnt_nxt = tcnt_r;  k_nxt = k_r;
    mcnt_nxt = mcnt_r;  dcnt_nxt = dcnt_r;  m_nxt = m_r;  b_nxt = b_r;
    p_nxt = p_r;  t_nxt = t_r;  d_nxt = d_r;  rem_nxt = rem_r;
    dneg_nxt = dneg_r;  qneg_nxt = qneg_r;  over_nxt = over_r;
    n_nxt = n_r;  q_nxt = q_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;  out_pos_nxt = out_pos_r;
    out_sing_nxt = out_sing_r;  out_sat_nxt = out_sat_r;  out_last_nxt = out_last_r;
    e_raddr = k_r;
    s_raddr = 4'd0;
    s_we    = 1'b0;
    s_waddr = {1'b0, tcnt_r[4:2]} + {1'b0, tcnt_r[4:2]} + {3'b0, tcnt_r[1]};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tdata[W+3:W] == 4'(LAST_POS))) begin
          ph_nxt    = PH_SUB;
          tcnt_nxt  = '0;
          t_nxt     = '0;
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        e_raddr   = x_addr;
        s_raddr   = x_addr;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        e_raddr   = y_addr;
        s_raddr   = y_addr;
        m_nxt     = (ph_r == PH_DET) ? s_rdata : {{(MW-W){e_rdata[W-1]}}, e_rdata};
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        b_nxt     = (ph_r == PH_SUB) ? {{(AW-W){e_rdata[W-1]}}, e_rdata}
                                     : {{(AW-MW){s_rdata[MW-1]}}, s_rdata};
        p_nxt     = '0;
        mcnt_nxt  = nb_m1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        p_nxt    = sum[AW-1:0];
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == '0) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        t_nxt     = sum[AW-1:0];
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        state_nxt = ST_RD0;
        tcnt_nxt  = tcnt_r + 1'b1;
        unique case (ph_r)
          PH_SUB: begin
            if (tcnt_r[0]) begin
              s_we  = 1'b1;
              t_nxt = '0;
            end
            if (tcnt_r == 5'(SUB_TERMS - 1)) begin
              ph_nxt   = PH_DET;
              tcnt_nxt = '0;
            end
          end
          PH_DET: begin
            if (tcnt_r == 5'(DET_TERMS - 1)) begin
              state_nxt = ST_DABS;
            end
          end
          PH_ADJ: begin
            if (tcnt_r == 5'(ADJ_TERMS - 1)) begin
              state_nxt = ST_NABS;
            end
          end
          default: ;
        endcase
      end
      ST_DABS: begin
        k_nxt = '0;
        if (t_r == '0) begin
          state_nxt = ST_SRD;
        end else begin
          dneg_nxt  = t_r[AW-1];
          d_nxt     = t_r[AW-1] ? sum[AW-1:0] : t_r;
          ph_nxt    = PH_ADJ;
          tcnt_nxt  = '0;
          t_nxt     = '0;
          state_nxt = ST_RD0;
        end
      end
      ST_NABS: begin
        qneg_nxt  = t_r[AW-1] ^ dneg_r;
        n_nxt     = {(t_r[AW-1] ? sum[NA-1:0] : t_r[NA-1:0]), {(2*FRAC_BITS){1'b0}}};
        rem_nxt   = '0;
        q_nxt     = '0;
        over_nxt  = 1'b0;
        dcnt_nxt  = DCW'(NB - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = sum[AW] ? sum[AW-1:0] : rem_sh;
        n_nxt    = {n_r[NB-2:0], 1'b0};
        q_nxt    = {q_r[W-2:0], sum[AW]};
        over_nxt = over_r || q_r[W-1];
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = fin_val;
          out_pos_nxt   = k_r;
          out_sing_nxt  = 1'b0;
          out_sat_nxt   = fin_sat;
          out_last_nxt  = (k_r == 4'(LAST_POS));
          k_nxt         = k_r + 1'b1;
          tcnt_nxt      = '0;
          t_nxt         = '0;
          state_nxt     = (k_r == 4'(LAST_POS)) ? ST_IDLE : ST_RD0;
        end
      end
      ST_SRD: begin
        state_nxt = ST_SOUT;
      end
      ST_SOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = e_rdata;
          out_pos_nxt   = k_r;
          out_sing_nxt  = 1'b1;
          out_sat_nxt   = 1'b0;
          out_last_nxt  = (k_r == 4'(LAST_POS));
          k_nxt         = k_r + 1'b1;
          state_nxt     = (k_r == 4'(LAST_POS)) ? ST_IDLE : ST_SRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_SUB;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tcnt_r <= tcnt_nxt;  k_r <= k_nxt;  mcnt_r <= mcnt_nxt;  dcnt_r <= dcnt_nxt;
    m_r <= m_nxt;  b_r <= b_nxt;  p_r <= p_nxt;  t_r <= t_nxt;  d_r <= d_nxt;
    rem_r <= rem_nxt;  dneg_r <= dneg_nxt;  qneg_r <= qneg_nxt;  over_r <= over_nxt;
    n_r <= n_nxt;  q_r <= q_nxt;
    out_value_r <= out_value_nxt;  out_pos_r <= out_pos_nxt;
    out_sing_r <= out_sing_nxt;  out_sat_r <= out_sat_nxt;  out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDW-W-4){1'b0}}, out_pos_r, out_value_r};
  assign out_tuser  = {out_sat_r, out_sing_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (d_r != '0))
    else $error("division started with zero divisor");

  a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_sing_r && out_sat_r))
    else $error("singular result flagged saturated");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tdata[W+3:W] == 4'(LAST_POS))) |=> !in_tready)
    else $error("input still ready after start of inversion");
`endif

endmodule

// File: design/m4inv_ram.sv
// ---------------------------------------------------------------------------
// m4inv_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module m4inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/matrix4x4_invert_test.sv
// ---------------------------------------------------------------------------
// matrix4x4_invert_test - self-checking bench for the 4x4 matrix inverter
// Streams column-major Q16.16 elements into the block. A scoreboard class
// keeps its own copy of the matrix store and, on every position-15 item,
// computes the sixteen expected inverse items (exact cofactor arithmetic,
// truncating division, saturation, singular pass-through). Output items are
// compared in order, field by field.
// ---------------------------------------------------------------------------
module matrix4x4_invert_test
  import m4inv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int TDW = ((DW + 4 + 7) / 8) * 8;
  // Covers the worst inversion with a long receiver stall on top.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [DW-1:0] value;
    logic [3:0]           pos;
    logic                 singular;
    logic                 sat;
    logic                 last;
  } inv_item_t;

  // Scoreboard: predicts inverse items and checks them in arrival order.
  class inverse_scoreboard;
    logic signed [DW-1:0] store [16];
    inv_item_t            pending [$];
    int                   errors;

    // Notes one accepted element; position 15 produces sixteen predictions.
    function void note_element(logic signed [DW-1:0] v, logic [3:0] p);
      logic signed [255:0] e [16];
      logic signed [255:0] s [12];
      logic signed [255:0] det, adj, num, den, quo, lim;
      inv_item_t it;
      store[p] = v;
      if (p != LAST_POS) return;
      for (int k = 0; k < 16; k++) e[k] = store[k];
      for (int k = 0; k < 12; k++)
        s[k] = e[SUB_TAB[k][0]] * e[SUB_TAB[k][1]] - e[SUB_TAB[k][2]] * e[SUB_TAB[k][3]];
      det = 0;
      for (int k = 0; k < DET_TERMS; k++)
        if (DET_NEG[k]) det = det - s[DET_A[k]] * s[DET_B[k]];
        else det = det + s[DET_A[k]] * s[DET_B[k]];
      for (int k = 0; k < 16; k++) begin
        it.pos = 4'(k);
        it.last = (k == 15);
        if (det == 0) begin
          // determinant zero: stored element comes back unchanged
          it.value = store[k];
          it.singular = 1'b1;
          it.sat = 1'b0;
        end else begin
          adj = e[ADJ_TAB[k][0]] * s[ADJ_TAB[k][1]] - e[ADJ_TAB[k][2]] * s[ADJ_TAB[k][3]]
              + e[ADJ_TAB[k][4]] * s[ADJ_TAB[k][5]];
          if (ADJ_NEG[k]) adj = -adj;
          num = (adj < 0 ? -adj : adj) <<< (2 * FB);
          den = det < 0 ? -det : det;
          quo = num / den;
          if ((adj < 0) != (det < 0)) quo = -quo;
          it.singular = 1'b0;
          it.sat = 1'b0;
          lim = (256'sd1 <<< (DW - 1));
          if (quo > lim - 1) begin
            quo = lim - 1;
            it.sat = 1'b1;
          end else if (quo < -lim) begin
            quo = -lim;
            it.sat = 1'b1;
          end
          it.value = quo[DW-1:0];
        end
        pending.push_back(it);
      end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task automatic check_result(inv_item_t got);
      inv_item_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item at pos", got.pos, 0);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) report_mismatch("value", got.value, want.value);
      if (got.pos !== want.pos) report_mismatch("position", got.pos, want.pos);
      if (got.singular !== want.singular)
        report_mismatch("singular", got.singular, want.singular);
      if (got.sat !== want.sat) report_mismatch("saturated", got.sat, want.sat);
      if (got.last !== want.last) report_mismatch("tlast", got.last, want.last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  inverse_scoreboard sb = new();
  int sender_idle_pct = 38;
  int receiver_idle_pct = 62;
  bit hold_receiver = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  matrix4x4_invert #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Receiver: random stalls, or a long hold when requested.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_receiver) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Output monitor; also feeds the watchdog.
  always @(posedge clk) begin
    inv_item_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[DW-1:0];
      got.pos = out_tdata[DW+3:DW];
      got.singular = out_tuser[0];
      got.sat = out_tuser[1];
      got.last = out_tlast;
      sb.check_result(got);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one element, with random idle gaps before it.
  // tvalid stays high after acceptance until the next call's idle gap or stop_input drops it.
  task automatic send_element(logic signed [DW-1:0] v, logic [3:0] p);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(TDW-DW-4){1'b0}}, p, v};
    do @(posedge clk); while (!in_tready);
    sb.note_element(v, p);
  endtask

  // Drops tvalid and waits for a clock edge.
  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_matrix(logic signed [DW-1:0] m [16]);
    for (int k = 0; k < 16; k++) send_element(m[k], 4'(k));
  endtask

  function automatic logic signed [DW-1:0] rand_elem(int kind);
    case (kind)
      0: return $urandom();                                   // full range
      1: return $signed($urandom_range(0, 8 << FB)) - (4 << FB); // moderate
      2: return $signed($urandom_range(0, 511)) - 256;         // tiny, may overflow
      default: return ($urandom_range(1) ? 32'sh7fffffff : 32'sh80000000);
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [DW-1:0] m [16];
    int kind;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity (plain inverse)
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? (1 <<< FB) : 0;
    send_matrix(m);
    // Singular: all zero except one rewrite of position 15; extremes of value
    for (int k = 0; k < 15; k++) send_element(0, 4'(k));
    send_element(32'sh7fffffff, 4'd15);
    // Scaled identity with extreme diagonal
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sh80000000 : 0;
    send_matrix(m);
    // Tiny diagonal: inverse overflows, saturates
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ((k == 10) ? -1 : 1) : 0;
    send_matrix(m);
    stop_input();
    wait_drained();

    // Pressure: receiver held for a long stretch while the sender keeps going.
    hold_receiver = 1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_receiver = 0;
      end
      begin
        for (int k = 0; k < 16; k++) m[k] = rand_elem(1);
        send_matrix(m);
        for (int k = 0; k < 4; k++) send_element(rand_elem(1), 4'(k));
        stop_input();
      end
    join
    wait_drained();

    // Random phases: sender/receiver idling swapped, then none.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 62 : 0;
      receiver_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 38 : 0;
      kind = $urandom_range(9);
      for (int k = 0; k < 16; k++) begin
        if (kind == 0) m[k] = rand_elem(0);
        else if (kind == 1) m[k] = rand_elem(2);
        else if (kind == 2) m[k] = rand_elem(3);
        else m[k] = rand_elem(1);
      end
      // sometimes force a singular matrix by copying a column
      if ($urandom_range(4) == 0) for (int r = 0; r < 4; r++) m[4 + r] = m[r];
      send_matrix(m);
      // sometimes a partial reload over the existing store: one element, then position 15
      if ($urandom_range(2) == 0) begin
        send_element(rand_elem(1), 4'($urandom_range(14)));
        send_element(rand_elem(1), 4'd15);
      end
      stop_input();
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: filelist.f
design/m4inv_pkg.sv
design/m4inv_ram.sv
design/matrix4x4_invert.sv
tb/sv/matrix4x4_invert_test.sv
